// File: rtl/cfb_pkg.sv
// ---------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the checksummed frame builder.
// ---------------------------------------------------------------------------
package cfb_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 24;
	localparam int unsigned SLOT_W = 4;

	localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_B = 8'h66;

	// byte positions within the run caused by one item
	localparam logic [SLOT_W-1:0] SLOT_HDR0 = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_HDR1 = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_HDR2 = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_LEN2 = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_LEN1 = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_LEN0 = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_TYPE = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_DATA = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_SUM  = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_TRL0 = 4'd9;
	localparam logic [SLOT_W-1:0] SLOT_TRL1 = 4'd10;
	localparam logic [SLOT_W-1:0] SLOT_TRL2 = 4'd11;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] ptype;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] csum;
		logic              reject;
		logic              ends;
	} cfb_item_t;

endpackage

// File: rtl/cfb_track.sv
// ---------------------------------------------------------------------------
// cfb_track
// Input stage: packet state (bytes left, running sum) and the item register.
// ---------------------------------------------------------------------------
module cfb_track (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cfb_pkg::BYTE_W-1:0]     payload_byte,
	input  logic [cfb_pkg::BYTE_W-1:0]     packet_type,
	input  logic [cfb_pkg::LEN_W-1:0]      payload_length,
	input  logic                           consume,
	output logic                           load,
	output logic                           load_start,
	output logic                           valid_s1,
	output cfb_pkg::cfb_item_t             item_s1
);
	import cfb_pkg::*;

	logic [LEN_W-1:0]  remaining_q;
	logic [BYTE_W-1:0] sum_q;
	logic              start;
	logic              reject;
	logic [LEN_W-1:0]  rem_next;
	logic [BYTE_W-1:0] sum_next;
	logic              ends;

	assign in_ready   = !valid_s1 || consume;
	assign load       = in_valid && in_ready;
	assign load_start = start;

	always_comb begin
		start    = (remaining_q == '0);
		reject   = start && (payload_length == '0);
		rem_next = (start ? payload_length : remaining_q) - LEN_W'(1);
		sum_next = (start ? packet_type : sum_q) + payload_byte;
		ends     = !reject && (rem_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			sum_q       <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				if (!reject) begin
					remaining_q <= rem_next;
					sum_q       <= ends ? '0 : sum_next;
				end
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.data   <= payload_byte;
			item_s1.ptype  <= packet_type;
			item_s1.len    <= payload_length;
			item_s1.csum   <= sum_next;
			item_s1.reject <= reject;
			item_s1.ends   <= ends;
		end
	end

endmodule

// File: rtl/cfb_emit.sv
// ---------------------------------------------------------------------------
// cfb_emit
// Serialiser: walks the byte run of the held item into the output register.
// ---------------------------------------------------------------------------
module cfb_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       valid_s1,
	input  cfb_pkg::cfb_item_t         item_s1,
	input  logic                       load_start,
	output logic                       consume,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cfb_pkg::BYTE_W-1:0] out_byte,
	output logic                       last_of_run,
	output logic                       end_of_frame,
	output logic                       rejected
);
	import cfb_pkg::*;

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] end_slot;
	logic              advance;
	logic              run_last;
	logic [BYTE_W-1:0] slot_byte;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              eof_q;
	logic              rej_q;

	always_comb begin
		end_slot = item_s1.ends ? SLOT_TRL2 : SLOT_DATA;
		advance  = valid_s1 && (!valid_q || out_ready);
		run_last = item_s1.reject || (slot_q == end_slot);
		consume  = advance && run_last;
		unique case (slot_q)
			SLOT_HDR0: slot_byte = SYNC_A;
			SLOT_HDR1: slot_byte = SYNC_B;
			SLOT_HDR2: slot_byte = SYNC_A;
			SLOT_LEN2: slot_byte = item_s1.len[23:16];
			SLOT_LEN1: slot_byte = item_s1.len[15:8];
			SLOT_LEN0: slot_byte = item_s1.len[7:0];
			SLOT_TYPE: slot_byte = item_s1.ptype;
			SLOT_DATA: slot_byte = item_s1.data;
			SLOT_SUM:  slot_byte = item_s1.csum;
			SLOT_TRL0: slot_byte = SYNC_B;
			SLOT_TRL1: slot_byte = SYNC_A;
			SLOT_TRL2: slot_byte = SYNC_B;
			default:   slot_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_HDR0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				slot_q <= load_start ? SLOT_HDR0 : SLOT_DATA;
			end else if (advance) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= item_s1.reject ? '0 : slot_byte;
			last_q <= run_last;
			eof_q  <= !item_s1.reject && (slot_q == SLOT_TRL2);
			rej_q  <= item_s1.reject;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;
	assign rejected     = rej_q;

endmodule

// File: rtl/checksummed_frame_builder_core.sv
// ---------------------------------------------------------------------------
// checksummed_frame_builder_core
// Frames payload bytes with header, length, type, checksum and trailer.
// ---------------------------------------------------------------------------
// Input channel s_axis: one payload byte per item; on a packet's first byte
// the type and 24-bit length are sampled too. Output channel m_axis: one
// framed byte per item, tlast on the final byte caused by an input item.
// The first byte of a packet yields 8 output items (AA 66 AA, length
// big-endian, type, byte); middle bytes yield 1; the last byte adds the
// checksum and 66 AA 66 (4 more items). A zero-length start yields a single
// item flagged rejected, and the byte is dropped.
// Accepted items are registered, then serialised. Throughput while
// m_axis_tready is high: one output item per cycle; an input item is taken
// every cycle while its run is one byte long, else once the serialiser
// reaches the run's last byte. The run length (1, 5, 8 or 12) sets the input
// rate. Reset clears packet state: the next byte opens a new packet. A stall
// on m_axis holds the output register and backs up to s_axis_tready.
// ---------------------------------------------------------------------------
module checksummed_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // payload_byte, packet_type, payload_length
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_byte
	output logic        m_axis_tlast,  // last_of_run
	output logic [1:0]  m_axis_tuser   // end_of_frame, rejected
);
	import cfb_pkg::*;

	logic      load;
	logic      load_start;
	logic      consume;
	logic      valid_s1;
	cfb_item_t item_s1;
	logic      eof;
	logic      rej;

	cfb_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.payload_byte   (s_axis_tdata[7:0]),
		.packet_type    (s_axis_tdata[15:8]),
		.payload_length (s_axis_tdata[39:16]),
		.consume        (consume),
		.load           (load),
		.load_start     (load_start),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1)
	);

	cfb_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.load_start   (load_start),
		.consume      (consume),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.last_of_run  (m_axis_tlast),
		.end_of_frame (eof),
		.rejected     (rej)
	);

	assign m_axis_tuser = {rej, eof};

endmodule
